/* sv/lsa_pkg.sv */
package lsa_pkg;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_RING  = 2'd1;
   localparam logic [1:0] OP_FRAME = 2'd2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INCLUDE_BOX = 1'd1;

   localparam logic [15:0] PHASE_STEP_RESET = 16'd104;
   localparam logic [31:0] RING_ON_MS       = 32'h7FFF_FFFF;
   localparam logic [7:0]  RING_MODE        = 8'd1;
   localparam logic [8:0]  UNIT_GAIN        = 9'd256;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   typedef struct packed {
      logic [1:0]  op;
      logic [5:0]  led_index;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [7:0]  effect_mode;
      logic [31:0] duration_ms;
      logic        ring_on;
      logic [31:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [5:0] pixel_index;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  mode;
      logic [31:0] timer;
   } led_entry_type;

   typedef struct packed {
      logic load;
      logic phase_adv;
      logic prep;
      logic wr_en;
      logic wr_ring;
      logic rd_en;
      logic wb;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic include_box;
   } status_type;

   // round(256*sin(pi/2 * k / 2^qbits)), Q30 series to the x^11 term
   function automatic logic [8:0] quarter_sine_q8(input logic [63:0] k, input int qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] s;
      logic [63:0] r;
      x    = (k * HALF_PI_Q30) >> qbits;
      x2   = (x * x) >> 30;
      pos  = x;
      neg  = 64'd0;
      term = ((x * x2) >> 30) / 64'd6;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 64'd20;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 64'd42;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 64'd72;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 64'd110;
      neg  = neg + term;
      s    = (pos > neg) ? pos - neg : 64'd0;
      r    = (s * 64'd256 + (ONE_Q30 >> 1)) >> 30;
      if (r > 64'd256) begin
         r = 64'd256;
      end
      return r[8:0];
   endfunction

endpackage

/* sv/lsa_stream_if.sv */
interface lsa_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* sv/led_strip_timed_pulse_animator.sv */
// Write word: table entry written in the accept cycle. Ring-light word: the accept cycle, then one
// LED table entry written per cycle (LED 0 skipped when include_box is clear). Frame word: phase
// advance in the accept cycle, gain set-up in the prep state, then one pixel per cycle through the
// single table read port when the sink keeps up; each entry is registered, then scaled.
// Synchronous active-high reset clears the per-entry valid bits at once (no clearing
// pass), the phase accumulator and the output valid flag, and presets the config registers.
module led_strip_timed_pulse_animator #(
   parameter int NUM_LEDS        = 32,
   parameter int SINE_TABLE_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   lsa_stream_if.sink                     req_ch,
   lsa_stream_if.source                   rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [lsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lsa_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import lsa_pkg::*;

   localparam int IDX_W = $clog2(NUM_LEDS);

   cmd_type          cmd;
   status_type       status;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;

   lsa_ctrl #(
      .NUM_LEDS (NUM_LEDS),
      .IDX_W    (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_data  (req_ch.data),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd),
      .wr_idx    (wr_idx),
      .rd_idx    (rd_idx)
   );

   lsa_datapath #(
      .NUM_LEDS        (NUM_LEDS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .IDX_W           (IDX_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .wr_idx      (wr_idx),
      .rd_idx      (rd_idx),
      .req_data    (req_ch.data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .rsp_ch      (rsp_ch)
   );

   a_single_write_port : assert property (@(posedge clock) disable iff (reset)
      !(cmd.wb && cmd.wr_en))
      else $error("write-back and table write in the same cycle");

   a_no_frame_when_ready : assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !cmd.rd_en && !cmd.wb)
      else $error("frame traffic while taking words");

   a_frame_blocks_input : assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.data.op == OP_FRAME |=> !req_ch.ready && cmd.prep)
      else $error("frame word not followed by gain set-up");

   a_wb_needs_room : assert property (@(posedge clock) disable iff (reset)
      cmd.wb |-> status.out_free)
      else $error("pixel loaded into occupied output register");

endmodule

/* sv/lsa_datapath.sv */
module lsa_datapath #(
   parameter int NUM_LEDS        = 32,
   parameter int SINE_TABLE_BITS = 8,
   parameter int IDX_W           = $clog2(NUM_LEDS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lsa_pkg::cmd_type              cmd,
   input  logic [IDX_W-1:0]              wr_idx,
   input  logic [IDX_W-1:0]              rd_idx,
   input  lsa_pkg::req_type              req_data,
   input  logic                          csr_wr_en,
   input  logic [lsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lsa_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output lsa_pkg::status_type           status,
   lsa_stream_if.source                  rsp_ch
);
   import lsa_pkg::*;

   localparam int SB      = SINE_TABLE_BITS;
   localparam int QUARTER = 1 << (SB - 2);
   localparam logic [SB-1:0] HALF_K    = SB'(1 << (SB - 1));
   localparam logic [SB-1:0] QUARTER_K = SB'(QUARTER);

   logic [8:0] sine_lut [QUARTER+1];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_lut
      localparam logic [8:0] VAL = quarter_sine_q8(64'(g), SB - 2);
      assign sine_lut[g] = VAL;
   end

   function automatic logic [SB-2:0] fold_index(input logic [15:0] m);
      logic [SB-1:0] kk;
      kk = {1'b0, m[15-1 -: SB-1]};
      if (kk > QUARTER_K) begin
         kk = HALF_K - kk;
      end
      return kk[SB-2:0];
   endfunction

   logic [15:0]   phase_step_ff, phase_step_in;
   logic          include_ff, include_in;
   logic [15:0]   phase_ff;
   logic [31:0]   elapsed_ff;
   logic          ring_on_ff;
   logic [8:0]    fac_ff [4];
   logic [8:0]    fac_in [4];

   led_entry_type mem [NUM_LEDS];
   logic [NUM_LEDS-1:0] valid_ff;
   led_entry_type rd_data_ff;
   logic          rd_valid_ff;
   logic [IDX_W-1:0] s1_idx_ff;

   logic          mem_we;
   logic [IDX_W-1:0] mem_waddr;
   led_entry_type mem_wdata;
   led_entry_type s1_entry;
   logic [31:0]   new_timer;
   logic [8:0]    gain;
   logic [16:0]   prod_r, prod_g, prod_b;

   rsp_type       rsp_ff, rsp_in;
   logic          rsp_v_ff, rsp_v_in;

   always_comb begin
      phase_step_in = phase_step_ff;
      include_in    = include_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PHASE_STEP:  phase_step_in = csr_wr_data;
            CSR_INCLUDE_BOX: include_in    = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RESET;
         include_ff    <= 1'b1;
         phase_ff      <= 16'd0;
      end else begin
         phase_step_ff <= phase_step_in;
         include_ff    <= include_in;
         if (cmd.phase_adv) begin
            phase_ff <= phase_ff + phase_step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         elapsed_ff <= req_data.elapsed_ms;
         ring_on_ff <= req_data.ring_on;
      end
      if (cmd.prep) begin
         fac_ff <= fac_in;
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         fac_in[j] = sine_lut[fold_index(phase_ff << j)];
      end
   end

   // stage 1: registered read, timer countdown and colour scaling
   always_comb begin
      s1_entry  = rd_valid_ff ? rd_data_ff : '0;
      new_timer = (s1_entry.timer > elapsed_ff) ? s1_entry.timer - elapsed_ff : 32'd0;
      case (s1_entry.mode)
         8'd2:    gain = fac_ff[0];
         8'd3:    gain = fac_ff[1];
         8'd4:    gain = fac_ff[2];
         8'd5:    gain = fac_ff[3];
         default: gain = UNIT_GAIN;
      endcase
      prod_r = 17'(s1_entry.red)   * 17'(gain);
      prod_g = 17'(s1_entry.green) * 17'(gain);
      prod_b = 17'(s1_entry.blue)  * 17'(gain);
   end

   always_comb begin
      mem_we    = cmd.wb || cmd.wr_en;
      mem_waddr = wr_idx;
      mem_wdata = '{red: req_data.red_in, green: req_data.green_in,
                    blue: req_data.blue_in, mode: req_data.effect_mode,
                    timer: req_data.duration_ms};
      if (cmd.wb) begin
         mem_waddr       = s1_idx_ff;
         mem_wdata       = s1_entry;
         mem_wdata.timer = new_timer;
      end else if (cmd.wr_ring) begin
         mem_wdata = '{red: {8{ring_on_ff}}, green: {8{ring_on_ff}},
                       blue: {8{ring_on_ff}}, mode: RING_MODE,
                       timer: ring_on_ff ? RING_ON_MS : 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_idx];
         s1_idx_ff  <= rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[mem_waddr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   always_comb begin
      rsp_in   = rsp_ff;
      rsp_v_in = rsp_v_ff && !rsp_ch.ready;
      if (cmd.wb) begin
         rsp_v_in           = 1'b1;
         rsp_in.pixel_index = 6'(s1_idx_ff);
         rsp_in.last_pixel  = (s1_idx_ff == IDX_W'(NUM_LEDS - 1));
         if (new_timer == 32'd0) begin
            rsp_in.red_out   = 8'd0;
            rsp_in.green_out = 8'd0;
            rsp_in.blue_out  = 8'd0;
         end else begin
            rsp_in.red_out   = prod_r[15:8];
            rsp_in.green_out = prod_g[15:8];
            rsp_in.blue_out  = prod_b[15:8];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   assign rsp_ch.valid       = rsp_v_ff;
   assign rsp_ch.data        = rsp_ff;
   assign status.out_free    = !rsp_v_ff || rsp_ch.ready;
   assign status.include_box = include_ff;

endmodule

/* sv/lsa_ctrl.sv */
module lsa_ctrl #(
   parameter int NUM_LEDS = 32,
   parameter int IDX_W    = $clog2(NUM_LEDS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  lsa_pkg::req_type    req_data,
   output logic                req_ready,
   input  lsa_pkg::status_type status,
   output lsa_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]    wr_idx,
   output logic [IDX_W-1:0]    rd_idx
);
   import lsa_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RING = 2'd1;
   localparam logic [1:0] ST_PREP = 2'd2;
   localparam logic [1:0] ST_RUN  = 2'd3;

   logic [1:0]     state_ff, state_in;
   logic [IDX_W:0] cnt_ff, cnt_in;
   logic           s1_v_ff, s1_v_in;
   logic           in_range;

   assign in_range = {1'b0, req_data.led_index} < 7'(NUM_LEDS);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      s1_v_in   = s1_v_ff;
      cmd       = '0;
      req_ready = 1'b0;
      wr_idx    = cnt_ff[IDX_W-1:0];
      rd_idx    = cnt_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            wr_idx    = req_data.led_index[IDX_W-1:0];
            if (req_valid) begin
               case (req_data.op)
                  OP_WRITE: cmd.wr_en = in_range;
                  OP_RING: begin
                     cmd.load = 1'b1;
                     cnt_in   = status.include_box ? '0 : (IDX_W+1)'(1);
                     state_in = ST_RING;
                  end
                  OP_FRAME: begin
                     cmd.load      = 1'b1;
                     cmd.phase_adv = 1'b1;
                     state_in      = ST_PREP;
                  end
                  default: ;
               endcase
            end
         end
         ST_RING: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_ring = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == (IDX_W+1)'(NUM_LEDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            s1_v_in  = 1'b0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.wb    = s1_v_ff && status.out_free;
            cmd.rd_en = (cnt_ff < (IDX_W+1)'(NUM_LEDS)) && !(s1_v_ff && !status.out_free);
            if (cmd.rd_en) begin
               cnt_in  = cnt_ff + 1'b1;
               s1_v_in = 1'b1;
            end else if (cmd.wb) begin
               s1_v_in = 1'b0;
            end
            if (cnt_ff == (IDX_W+1)'(NUM_LEDS) && (!s1_v_ff || cmd.wb)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         s1_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         s1_v_ff  <= s1_v_in;
      end
   end

endmodule
